[rtl/core/spi_master_byte_shifter_top_defines.svh]
// Assertion macros for the checker file of the byte shifter.
`ifndef SPI_MASTER_BYTE_SHIFTER_TOP_DEFINES_SVH
`define SPI_MASTER_BYTE_SHIFTER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SMBS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("smbs: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SMBS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("smbs: next-cycle check failed");

`endif

[rtl/core/smbs_pkg.sv]
// Types and constants shared by the SPI master byte shifter files.
package smbs_pkg;

  localparam int BITS_PER_BYTE = 8;
  localparam logic [2:0] LAST_BIT = 3'(BITS_PER_BYTE - 1);
  localparam int CFG_WIDTH = 16;

  // Depth of the queues between the front, the shifter and the result side.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic       load_valid;
    logic [7:0] tx_byte;
    logic       end_of_frame;
    logic       miso_level;
  } in_item_t;

  typedef struct packed {
    logic       sclk_level;
    logic       mosi_level;
    logic       select_n;
    logic       load_ready;
    logic       rx_valid;
    logic [7:0] rx_byte;
  } out_item_t;

  // The four phases of one bit.
  typedef enum logic [3:0] {
    PH_CLK_LOW  = 4'b0001,
    PH_DRIVE    = 4'b0010,
    PH_CLK_HIGH = 4'b0100,
    PH_SAMPLE   = 4'b1000
  } phase_t;

  // Handshake status of one queue as seen by its neighbors.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

[rtl/core/spi_master_byte_shifter_top.sv]
// Top level of the SPI master byte shifter (mode 0, most significant bit first).
//
// Each input beat is one tick of the pin-level shifter: an optional byte to
// send with its end-of-frame mark, and the sampled MISO level. Each input
// beat yields exactly one result beat with the SCLK, MOSI and select levels
// after that tick, the load-ready flag, and a received byte when one ends.
// Input beats are pushed with in_push while in_full is low; results are
// taken with out_pop while out_empty is low, oldest first.
// The phase_delay register is written through cfg_we and cfg_data; the user
// must write it only while no beat is in flight; the block does not enforce it.
// Throughput is one beat per cycle while neither side stalls: the shifter
// steps once per cycle, limited only by its single-tick state update. An
// accepted input beat is registered in the input queue, and its result in
// the result queue, before it reaches the output.
// If the receiver stalls, the result queue fills, the shifter stops
// stepping and the input queue fills, raising in_full; nothing is lost.
// A synchronous low rst_n empties both queues, idles the shifter with
// select high, and sets phase_delay back to one.
module spi_master_byte_shifter_top import smbs_pkg::*; #(
  parameter int DELAY_WIDTH = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  output logic                 in_full,
  input  in_item_t             in_item,
  output logic                 out_empty,
  input  logic                 out_pop,
  output out_item_t            out_item,
  input  logic                 cfg_we,
  input  logic [CFG_WIDTH-1:0] cfg_data
);

  // Register value widened first so that any DELAY_WIDTH up to 32 can take
  // its low bits, dropping or zero-filling as needed.
  logic [31:0]            cfg_wide;
  logic [DELAY_WIDTH-1:0] phase_delay_r, phase_delay_nxt;
  q_status_t              in_q_status, out_q_status;
  in_item_t               head_item;
  out_item_t              step_result;
  logic                   step;

  assign cfg_wide        = {{(32 - CFG_WIDTH){1'b0}}, cfg_data};
  assign phase_delay_nxt = cfg_wide[DELAY_WIDTH-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_delay_r <= DELAY_WIDTH'(1);
    end else if (cfg_we) begin
      phase_delay_r <= phase_delay_nxt;
    end
  end

  // Front: input beats wait here until the shifter takes them.
  smbs_queue #(
    .WIDTH ($bits(in_item_t))
  ) u_in_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (in_push),
    .wr_data (in_item),
    .pop     (step),
    .rd_data (head_item),
    .status  (in_q_status)
  );

  // The shifter advances one tick whenever a beat waits and the result
  // queue has room for its result.
  assign step = ~in_q_status.empty & ~out_q_status.full;

  smbs_shift_core #(
    .DELAY_WIDTH (DELAY_WIDTH)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .phase_delay (phase_delay_r),
    .tick        (head_item),
    .result      (step_result)
  );

  // Back: results wait here until the receiver pops them.
  smbs_queue #(
    .WIDTH ($bits(out_item_t))
  ) u_out_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (step),
    .wr_data (step_result),
    .pop     (out_pop),
    .rd_data (out_item),
    .status  (out_q_status)
  );

  assign in_full   = in_q_status.full;
  assign out_empty = out_q_status.empty;

endmodule

[rtl/core/smbs_queue.sv]
// Small first-in first-out queue of fixed depth that decouples two stages.
module smbs_queue import smbs_pkg::*; #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output q_status_t        status
);

  logic [WIDTH-1:0]  slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_push, do_pop;

  assign status.full  = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign status.empty = (count_r == '0);
  assign do_push = push & ~status.full;
  assign do_pop  = pop & ~status.empty;
  assign rd_data = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

[rtl/core/smbs_shift_core.sv]
// Pin-level shifter: advances the SPI state by one tick per stepped beat.
module smbs_shift_core import smbs_pkg::*; #(
  parameter int DELAY_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   step,
  input  logic [DELAY_WIDTH-1:0] phase_delay,
  input  in_item_t               tick,
  output out_item_t              result
);

  phase_t                 phase_r, phase_nxt;
  logic [DELAY_WIDTH-1:0] wait_r, wait_nxt;
  logic [2:0]             bit_idx_r, bit_idx_nxt;
  logic [7:0]             tx_shift_r, tx_shift_nxt;
  logic [7:0]             rx_shift_r, rx_shift_nxt;
  logic                   active_r, active_nxt;
  logic                   selected_r, selected_nxt;
  logic                   last_r, last_nxt;
  logic                   sclk_r, sclk_nxt;
  logic                   mosi_r, mosi_nxt;
  logic                   rx_valid;
  logic [7:0]             rx_out;

  always_comb begin
    phase_nxt    = phase_r;
    wait_nxt     = wait_r;
    bit_idx_nxt  = bit_idx_r;
    tx_shift_nxt = tx_shift_r;
    rx_shift_nxt = rx_shift_r;
    active_nxt   = active_r;
    selected_nxt = selected_r;
    last_nxt     = last_r;
    sclk_nxt     = sclk_r;
    mosi_nxt     = mosi_r;
    rx_valid     = 1'b0;
    rx_out       = '0;

    if (!active_r) begin
      if (tick.load_valid) begin
        tx_shift_nxt = tick.tx_byte;
        rx_shift_nxt = '0;
        last_nxt     = tick.end_of_frame;
        active_nxt   = 1'b1;
        selected_nxt = 1'b1;
        bit_idx_nxt  = '0;
        phase_nxt    = PH_CLK_LOW;
        wait_nxt     = '0;
        sclk_nxt     = 1'b0;
      end
    end else if (wait_r < phase_delay) begin
      wait_nxt = wait_r + DELAY_WIDTH'(1);
    end else begin
      wait_nxt = '0;
      case (phase_r)
        PH_CLK_LOW: begin
          phase_nxt    = PH_DRIVE;
          mosi_nxt     = tx_shift_r[7];
          tx_shift_nxt = {tx_shift_r[6:0], 1'b0};
        end
        PH_DRIVE: begin
          phase_nxt = PH_CLK_HIGH;
          sclk_nxt  = 1'b1;
        end
        PH_CLK_HIGH: begin
          phase_nxt    = PH_SAMPLE;
          rx_shift_nxt = {rx_shift_r[6:0], tick.miso_level};
        end
        PH_SAMPLE: begin
          if (bit_idx_r != LAST_BIT) begin
            bit_idx_nxt = bit_idx_r + 3'd1;
            phase_nxt   = PH_CLK_LOW;
            sclk_nxt    = 1'b0;
          end else begin
            rx_valid    = 1'b1;
            rx_out      = rx_shift_r;
            active_nxt  = 1'b0;
            phase_nxt   = PH_CLK_LOW;
            bit_idx_nxt = '0;
            if (last_r) begin
              selected_nxt = 1'b0;
            end
            last_nxt = 1'b0;
          end
        end
        default: begin
          phase_nxt = PH_CLK_LOW;
        end
      endcase
    end
  end

  // The result shows the line state after this tick.
  assign result.sclk_level = sclk_nxt;
  assign result.mosi_level = mosi_nxt;
  assign result.select_n   = ~selected_nxt;
  assign result.load_ready = ~active_nxt;
  assign result.rx_valid   = rx_valid;
  assign result.rx_byte    = rx_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_CLK_LOW;
      wait_r     <= '0;
      bit_idx_r  <= '0;
      tx_shift_r <= '0;
      rx_shift_r <= '0;
      active_r   <= 1'b0;
      selected_r <= 1'b0;
      last_r     <= 1'b0;
      sclk_r     <= 1'b0;
      mosi_r     <= 1'b0;
    end else if (step) begin
      phase_r    <= phase_nxt;
      wait_r     <= wait_nxt;
      bit_idx_r  <= bit_idx_nxt;
      tx_shift_r <= tx_shift_nxt;
      rx_shift_r <= rx_shift_nxt;
      active_r   <= active_nxt;
      selected_r <= selected_nxt;
      last_r     <= last_nxt;
      sclk_r     <= sclk_nxt;
      mosi_r     <= mosi_nxt;
    end
  end

endmodule

[rtl/core/smbs_checker.sv]
// Port-level checker for the byte shifter and its bind to the top level.
`include "spi_master_byte_shifter_top_defines.svh"

module smbs_checker import smbs_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      out_empty,
  input logic      out_pop,
  input out_item_t out_item
);

  // A result beat without a received byte carries a zero byte.
  `SMBS_ASSERT_NOW(a_rx_zero, clk, rst_n, !out_empty && !out_item.rx_valid, out_item.rx_byte == 8'd0)

  // A byte completes only as the shifter goes idle.
  `SMBS_ASSERT_NOW(a_rx_idle, clk, rst_n, !out_empty && out_item.rx_valid, out_item.load_ready)

  // While the shifter is busy, select is held low.
  `SMBS_ASSERT_NOW(a_busy_sel, clk, rst_n, !out_empty && !out_item.load_ready, !out_item.select_n)

  // A waiting result that is not popped stays offered.
  `SMBS_ASSERT_NEXT(a_hold, clk, rst_n, rst_n && !out_empty && !out_pop, !out_empty && $stable(out_item))

endmodule

bind spi_master_byte_shifter_top smbs_checker u_smbs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_empty (out_empty),
  .out_pop   (out_pop),
  .out_item  (out_item)
);

[bench/spi_master_byte_shifter_top_tb.sv]
// Self-checking testbench for the SPI master byte shifter top level.
`timescale 1ns / 1ps

module spi_master_byte_shifter_top_tb;
  import smbs_pkg::*;

  // Which side, if any, pauses at random in the current phase of the run.
  typedef enum int {
    STALL_NONE,
    STALL_SENDER,
    STALL_RECEIVER,
    STALL_BOTH
  } stall_mode_t;

  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_LIMIT = 20000;
  localparam logic [CFG_WIDTH-1:0] DELAY_AT_RESET = 16'd1;
  localparam logic [CFG_WIDTH-1:0] DELAY_MIN = 16'd0;
  localparam logic [CFG_WIDTH-1:0] DELAY_MAX = 16'hFFFF;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // Every input of the block starts at a known value.
  logic                 in_push = 1'b0;
  logic                 in_full;
  in_item_t             in_item = '0;
  logic                 out_empty;
  logic                 out_pop = 1'b0;
  out_item_t            out_item;
  logic                 cfg_we = 1'b0;
  logic [CFG_WIDTH-1:0] cfg_data = '0;

  spi_master_byte_shifter_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_item   (in_item),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  // Tick beats waiting to be offered, and pin levels still owed by the block.
  in_item_t  ticks_to_send[$];
  out_item_t pin_levels_due[$];

  stall_mode_t stall_mode = STALL_NONE;

  // Set at each rising edge: the tick beat on the bus was taken there.
  logic in_taken = 1'b0;

  // Long receiver hold-off requests: the initial block bumps hold_asked and
  // the pop process answers by holding out_pop low while it counts down from HOLD_CYCLES.
  int unsigned hold_asked = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;

  int unsigned mismatches = 0;
  int unsigned beats_in = 0;
  int unsigned beats_out = 0;
  int unsigned bytes_received = 0;
  int unsigned frames_closed = 0;
  int unsigned delay_writes = 0;
  logic        select_seen = 1'b1;

  // Shadow copy of the shifter state and its one register. DELAY_WIDTH is
  // left at 16, so the register keeps every bit that is written.
  logic [CFG_WIDTH-1:0] delay_reg;
  phase_t               sh_phase;
  logic [CFG_WIDTH-1:0] sh_wait;
  logic [2:0]           sh_bit;
  logic [7:0]           sh_tx;
  logic [7:0]           sh_rx;
  logic                 sh_busy;
  logic                 sh_sel;
  logic                 sh_last;
  logic                 sh_clk;
  logic                 sh_mosi;

  initial begin
    forever #2 clk = ~clk;
  end

  // Generous fixed limit, far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // Entering a phase does its pin action at once and restarts the hold count.
  function automatic void enter_phase(phase_t ph, logic miso);
    sh_phase = ph;
    sh_wait = '0;
    case (ph)
      PH_CLK_LOW: sh_clk = 1'b0;
      PH_DRIVE: begin
        sh_mosi = sh_tx[7];
        sh_tx = {sh_tx[6:0], 1'b0};
      end
      PH_CLK_HIGH: sh_clk = 1'b1;
      default: sh_rx = {sh_rx[6:0], miso};
    endcase
  endfunction

  // One tick of the shifter: returns the pin levels after the tick.
  function automatic out_item_t shift_tick(in_item_t beat);
    out_item_t levels;
    levels = '0;
    if (!sh_busy) begin
      // Idle: an offered byte starts a transfer and drops select. A frame
      // mark without an offer is simply dropped.
      if (beat.load_valid) begin
        sh_tx = beat.tx_byte;
        sh_rx = '0;
        sh_last = beat.end_of_frame;
        sh_busy = 1'b1;
        sh_sel = 1'b1;
        sh_bit = '0;
        enter_phase(PH_CLK_LOW, beat.miso_level);
      end
    end else if (sh_wait < delay_reg) begin
      // A lowered delay ends the phase as soon as the count has reached it.
      sh_wait = sh_wait + 1'b1;
    end else if (sh_phase != PH_SAMPLE) begin
      enter_phase(phase_t'(sh_phase << 1), beat.miso_level);
    end else if (sh_bit != LAST_BIT) begin
      sh_bit = sh_bit + 1'b1;
      enter_phase(PH_CLK_LOW, beat.miso_level);
    end else begin
      // Completion tick: still busy at its start, so an offer here is lost.
      levels.rx_valid = 1'b1;
      levels.rx_byte = sh_rx;
      sh_busy = 1'b0;
      sh_phase = PH_CLK_LOW;
      sh_wait = '0;
      sh_bit = '0;
      if (sh_last) begin
        sh_sel = 1'b0;
      end
      sh_last = 1'b0;
    end
    levels.sclk_level = sh_clk;
    levels.mosi_level = sh_mosi;
    levels.select_n = !sh_sel;
    levels.load_ready = !sh_busy;
    return levels;
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  // True when the given side should sit out this cycle.
  function automatic bit roll_stall(bit sender_side);
    stall_mode_t own;
    own = sender_side ? STALL_SENDER : STALL_RECEIVER;
    if (stall_mode == own) begin
      return $urandom_range(0, 99) < 67;
    end
    if (stall_mode == STALL_BOTH) begin
      return $urandom_range(0, 99) < 23;
    end
    return 1'b0;
  endfunction

  // A random tick. The byte leans toward its extremes now and then.
  function automatic in_item_t random_tick(int load_pct);
    in_item_t beat;
    int       pick;
    pick = $urandom_range(0, 7);
    beat.load_valid = $urandom_range(0, 99) < load_pct;
    beat.tx_byte = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom);
    beat.end_of_frame = 1'($urandom_range(0, 1));
    beat.miso_level = 1'($urandom_range(0, 1));
    return beat;
  endfunction

  // Rising edge: note what each handshake moved, keep the shadow model in
  // step with accepted tick beats, and check every popped result beat.
  always @(posedge clk) begin : watch_beats
    out_item_t want;
    in_taken <= rst_n && in_push && !in_full;
    if (!rst_n) begin
      delay_reg = DELAY_AT_RESET;
      sh_phase = PH_CLK_LOW;
      sh_wait = '0;
      sh_bit = '0;
      sh_tx = '0;
      sh_rx = '0;
      sh_busy = 1'b0;
      sh_sel = 1'b0;
      sh_last = 1'b0;
      sh_clk = 1'b0;
      sh_mosi = 1'b0;
    end else begin
      // Writes only happen with no beat in flight, so order does not matter.
      if (cfg_we) begin
        delay_reg = cfg_data;
      end
      if (in_push && !in_full) begin
        pin_levels_due.push_back(shift_tick(in_item));
        beats_in++;
      end
      if (out_pop && !out_empty) begin
        beats_out++;
        if (pin_levels_due.size() == 0) begin
          $error("result beat arrived with none expected");
          mismatches++;
        end else begin
          want = pin_levels_due.pop_front();
          check_field("sclk_level", 8'(want.sclk_level), 8'(out_item.sclk_level));
          check_field("mosi_level", 8'(want.mosi_level), 8'(out_item.mosi_level));
          check_field("select_n", 8'(want.select_n), 8'(out_item.select_n));
          check_field("load_ready", 8'(want.load_ready), 8'(out_item.load_ready));
          check_field("rx_valid", 8'(want.rx_valid), 8'(out_item.rx_valid));
          check_field("rx_byte", want.rx_byte, out_item.rx_byte);
          if (want.rx_valid) begin
            bytes_received++;
          end
          if (want.select_n && !select_seen) begin
            frames_closed++;
          end
          select_seen = want.select_n;
        end
      end
    end
  end

  // Sender: once the bus slot is free, present the next queued tick or, on
  // a random stall, leave the bus idle. A beat waiting on in_full is held.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
    end else if (!in_push || in_taken) begin
      if (ticks_to_send.size() != 0 && !roll_stall(1'b1)) begin
        in_item <= ticks_to_send.pop_front();
        in_push <= 1'b1;
      end else begin
        in_push <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus the long hold-off that fills the block
  // and pushes back on the sender.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_pop <= 1'b0;
    end else if (hold_seen != hold_asked) begin
      hold_seen <= hold_asked;
      hold_left <= HOLD_CYCLES;
      out_pop <= 1'b0;
    end else begin
      out_pop <= !roll_stall(1'b0);
    end
  end

  // Waits until every queued tick was taken and every result has come back.
  // This is also the point where the sender pauses for a drained block.
  task automatic wait_drained();
    int spent;
    spent = 0;
    while ((ticks_to_send.size() != 0 || in_push || pin_levels_due.size() != 0)
           && spent < DRAIN_LIMIT) begin
      @(negedge clk);
      spent++;
    end
    repeat (4) @(negedge clk);
  endtask

  // Register write, only ever made with nothing in flight.
  task automatic write_delay(logic [CFG_WIDTH-1:0] value);
    @(negedge clk);
    cfg_data <= value;
    cfg_we <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
    delay_writes++;
  endtask

  // One phase of the random part: drain, set the delay, stall mode and any long
  // hold-off, then queue random ticks. A high load rate keeps a byte offered on
  // nearly every tick, so transfers run back to back and hit the completion tick.
  task automatic run_phase(logic [CFG_WIDTH-1:0] delay, int count, int load_pct,
                           stall_mode_t mode, bit long_hold);
    wait_drained();
    write_delay(delay);
    stall_mode = mode;
    if (long_hold) begin
      hold_asked++;
    end
    repeat (count) ticks_to_send.push_back(random_tick(load_pct));
  endtask

  initial begin : stimulus
    in_item_t beat;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed start at the reset delay. Two frame marks with no byte
    // offered must leave select high.
    beat = '0;
    beat.end_of_frame = 1'b1;
    beat.miso_level = 1'b1;
    ticks_to_send.push_back(beat);
    beat.miso_level = 1'b0;
    ticks_to_send.push_back(beat);
    // All ones out, all ones sampled, not the last byte of its frame.
    beat = '{load_valid: 1'b1, tx_byte: 8'hFF, end_of_frame: 1'b0, miso_level: 1'b1};
    ticks_to_send.push_back(beat);
    // Offers made while busy, with their frame marks, must change nothing.
    for (int i = 0; i < 18; i++) begin
      beat = '{load_valid: 1'b1, tx_byte: 8'h00, end_of_frame: 1'b1,
               miso_level: 1'(i % 3 != 0)};
      ticks_to_send.push_back(beat);
    end

    // The first byte is still mid-transfer when the delay drops to zero.
    run_phase(DELAY_MIN, 300, 100, STALL_NONE, 1'b0);
    run_phase(16'd3, 250, 50, STALL_SENDER, 1'b0);
    // Largest delay: the shifter sits in one phase for the whole stretch...
    run_phase(DELAY_MAX, 60, 60, STALL_RECEIVER, 1'b0);
    // ...until the delay drops below the count it has reached.
    run_phase(DELAY_MIN, 200, 100, STALL_BOTH, 1'b0);
    run_phase(16'd1, 250, 30, STALL_NONE, 1'b1);
    run_phase(16'd2, 300, 70, STALL_SENDER, 1'b0);
    // Sparse offers: mostly idle ticks between frames.
    run_phase(DELAY_MIN, 250, 5, STALL_RECEIVER, 1'b0);
    run_phase(16'd4, 200, 100, STALL_BOTH, 1'b0);
    run_phase(DELAY_MIN, 150, 80, STALL_NONE, 1'b0);

    wait_drained();
    stall_mode = STALL_NONE;
    repeat (8) @(negedge clk);
    if (pin_levels_due.size() != 0) begin
      $error("%0d result beats never arrived", pin_levels_due.size());
      mismatches++;
    end

    $display("Covered %0d tick beats in, %0d result beats out, %0d received bytes,",
             beats_in, beats_out, bytes_received);
    $display("%0d frames closed by select, %0d delay writes, %0d mismatches.",
             frames_closed, delay_writes, mismatches);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[spi_master_byte_shifter_top.f]
+incdir+rtl/core
rtl/core/smbs_pkg.sv
rtl/core/smbs_queue.sv
rtl/core/smbs_shift_core.sv
rtl/core/spi_master_byte_shifter_top.sv
rtl/core/smbs_checker.sv
bench/spi_master_byte_shifter_top_tb.sv
